/* rtl/core/fpcm_pkg.sv */
`timescale 1ns / 1ps

package fpcm_pkg;

   localparam logic [1:0] FMT_FLOAT = 2'd0;
   localparam logic [1:0] FMT_PCM16 = 2'd1;
   localparam logic [1:0] FMT_PCM24 = 2'd2;
   localparam logic [1:0] FMT_PCM32 = 2'd3;

   localparam logic [1:0] CSR_FORMAT = 2'd0;
   localparam logic [1:0] CSR_VOL_EN = 2'd1;
   localparam logic [1:0] CSR_GAIN   = 2'd2;

   localparam logic [24:0] UNITY_GAIN = 25'h1000000;

   typedef struct packed {
      logic [1:0]  fmt;
      logic        vol_en;
      logic [24:0] gain;
   } cfg_type;

   typedef struct packed {
      logic [31:0] bits;
      logic        last;
   } sample_type;

   function automatic logic [30:0] full_scale(input logic [1:0] fmt);
      logic [30:0] k;
      case (fmt)
         FMT_PCM16: k = 31'd32767;
         FMT_PCM24: k = 31'd8388607;
         default:   k = 31'h7FFFFFFF;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] byte_count(input logic [1:0] fmt);
      logic [2:0] n;
      case (fmt)
         FMT_PCM16: n = 3'd2;
         FMT_PCM24: n = 3'd3;
         default:   n = 3'd4;
      endcase
      return n;
   endfunction

endpackage

/* rtl/core/float_to_pcm_sample_converter.sv */
`timescale 1ns / 1ps

// Converts one single precision audio sample per word into float32, pcm16, pcm24 or
// pcm32, with an optional software gain below unity applied first. The pipeline is
// five register stages deep: an accepted sample loads stage 1 and moves on through
// stages 2 to 4 into stage 5, whose register drives rsp_tvalid. It accepts one word
// in every clock cycle while the result side does not stall, because each stage, the
// gain and full-scale multipliers included, takes a new word once its last one moves
// on. A stall on the result side holds every full stage without losing or repeating
// a word. Bubbles are squeezed out, so req_tready stays high while any stage is
// empty. The configuration channel is always ready and a write takes effect from the
// next cycle, so write the registers only while no words are in flight.

module float_to_pcm_sample_converter import fpcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_bits
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] sample_word, [34:32] valid_bytes, rest zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_data
);

   cfg_type    cfg_ff;
   sample_type req_sample;
   sample_type mid_sample;
   logic       mid_valid;
   logic       mid_ready;
   logic [31:0] word;
   logic [2:0]  bytes;

   assign csr_ready       = 1'b1;
   assign req_sample.bits = req_tdata;
   assign req_sample.last = req_tlast;
   assign rsp_tdata       = {5'd0, bytes, word};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt    <= FMT_PCM16;
         cfg_ff.vol_en <= 1'b0;
         cfg_ff.gain   <= UNITY_GAIN;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FORMAT: cfg_ff.fmt    <= csr_data[1:0];
            CSR_VOL_EN: cfg_ff.vol_en <= csr_data[0];
            CSR_GAIN:   cfg_ff.gain   <= csr_data;
            default:    cfg_ff        <= cfg_ff;
         endcase
      end
   end

   fpcm_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_sample),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_sample (mid_sample)
   );

   fpcm_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_sample (mid_sample),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (word),
      .out_bytes (bytes),
      .out_last  (rsp_tlast)
   );

endmodule

/* rtl/core/fpcm_scale.sv */
`timescale 1ns / 1ps

module fpcm_scale import fpcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  sample_type in_sample,
   output logic       out_valid,
   input  logic       out_ready,
   output sample_type out_sample
);

   logic en1, en2, en3;

   logic        v1_ff, v2_ff, v3_ff;
   logic        byp1_ff, byp1_in;
   logic [31:0] val1_ff, val1_in;
   logic [47:0] prod1_ff, prod1_in;
   logic [7:0]  ee1_ff, ee1_in;
   logic        last1_ff;

   logic              byp2_ff, byp2_in;
   logic [31:0]       val2_ff, val2_in;
   logic [47:0]       prod2_ff;
   logic [7:0]        ee2_ff;
   logic signed [5:0] shift2_ff, shift2_in;
   logic              last2_ff;

   sample_type out3_ff, out3_in;

   assign en3       = !v3_ff || out_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v3_ff;
   assign out_sample = out3_ff;

   // Stage 1: NaN cleanup, special cases and the mantissa by gain product.
   always_comb begin
      logic        is_nan;
      logic [31:0] s;
      logic [7:0]  e;
      logic [22:0] f;
      logic [23:0] mant;
      is_nan  = (&in_sample.bits[30:23]) && (|in_sample.bits[22:0]);
      s       = is_nan ? 32'd0 : in_sample.bits;
      e       = s[30:23];
      f       = s[22:0];
      byp1_in = 1'b0;
      val1_in = s;
      if (!(cfg.vol_en && !cfg.gain[24])) begin
         byp1_in = 1'b1;
      end else if (e == 8'hFF) begin
         byp1_in = 1'b1;
         if (cfg.gain[23:0] == 24'd0) begin
            val1_in = 32'd0;
         end
      end else if (e == 8'd0 && f == 23'd0) begin
         byp1_in = 1'b1;
      end
      mant     = {(e != 8'd0), f};
      ee1_in   = (e != 8'd0) ? e : 8'd1;
      prod1_in = mant * cfg.gain[23:0];
   end

   // Stage 2: leading one of the product and the alignment shift.
   always_comb begin
      logic [5:0]        hb;
      logic signed [9:0] sh_a;
      logic signed [9:0] sh_b;
      logic signed [9:0] sh_w;
      hb = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (prod1_ff[i]) begin
            hb = 6'(i);
         end
      end
      sh_a      = $signed({4'b0, hb}) - 10'sd23;
      sh_b      = 10'sd25 - $signed({2'b0, ee1_ff});
      sh_w      = (sh_a > sh_b) ? sh_a : sh_b;
      shift2_in = sh_w[5:0];
      byp2_in   = byp1_ff || (prod1_ff == 48'd0);
      val2_in   = byp1_ff ? val1_ff : {val1_ff[31], 31'd0};
   end

   // Stage 3: align, round to nearest even and pack the single.
   always_comb begin
      logic [5:0]        neg;
      logic [71:0]       wide;
      logic [23:0]       q_trunc;
      logic              rnd;
      logic [24:0]       q_rnd;
      logic signed [9:0] exp_w;
      logic [22:0]       mant;
      logic              normal;
      neg  = -shift2_ff;
      wide = {prod2_ff, 24'd0} >> shift2_ff[4:0];
      if (shift2_ff[5]) begin
         q_trunc = prod2_ff[23:0] << neg[4:0];
         rnd     = 1'b0;
      end else begin
         q_trunc = wide[47:24];
         rnd     = wide[23] && ((|wide[22:0]) || wide[24]);
      end
      q_rnd  = {1'b0, q_trunc} + {24'd0, rnd};
      exp_w  = $signed({2'b0, ee2_ff}) - 10'sd24 + 10'(shift2_ff)
               + $signed({9'd0, q_rnd[24]});
      mant   = q_rnd[24] ? q_rnd[23:1] : q_rnd[22:0];
      normal = q_rnd[24] | q_rnd[23];
      out3_in.last = last2_ff;
      out3_in.bits = byp2_ff ? val2_ff
                             : {val2_ff[31], (normal ? exp_w[7:0] : 8'd0), mant};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         byp1_ff  <= byp1_in;
         val1_ff  <= val1_in;
         prod1_ff <= prod1_in;
         ee1_ff   <= ee1_in;
         last1_ff <= in_sample.last;
      end
      if (en2) begin
         byp2_ff   <= byp2_in;
         val2_ff   <= val2_in;
         prod2_ff  <= prod1_ff;
         ee2_ff    <= ee1_ff;
         shift2_ff <= shift2_in;
         last2_ff  <= last1_ff;
      end
      if (en3) begin
         out3_ff <= out3_in;
      end
   end

endmodule

/* rtl/core/fpcm_quant.sv */
`timescale 1ns / 1ps

module fpcm_quant import fpcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  sample_type  in_sample,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_word,
   output logic [2:0]  out_bytes,
   output logic        out_last
);

   logic en4, en5;

   logic        v4_ff, v5_ff;
   logic [31:0] bits4_ff;
   logic        last4_ff;
   logic        zero4_ff, zero4_in;
   logic        sat4_ff, sat4_in;
   logic [54:0] prod4_ff, prod4_in;
   logic [7:0]  sh4_ff, sh4_in;

   logic [31:0] word5_ff, word5_in;
   logic [2:0]  bytes5_ff;
   logic        last5_ff;

   assign en5       = !v5_ff || out_ready;
   assign en4       = !v4_ff || en5;
   assign in_ready  = en4;
   assign out_valid = v5_ff;
   assign out_word  = word5_ff;
   assign out_bytes = bytes5_ff;
   assign out_last  = last5_ff;

   // Stage 4: classify the sample and form the exact product with full scale.
   always_comb begin
      logic [7:0]  e;
      logic [22:0] f;
      logic [23:0] mant;
      e        = in_sample.bits[30:23];
      f        = in_sample.bits[22:0];
      zero4_in = (e == 8'd0) && (f == 23'd0);
      sat4_in  = (e > 8'd127) || ((e == 8'd127) && (f != 23'd0));
      mant     = {(e != 8'd0), f};
      prod4_in = mant * full_scale(cfg.fmt);
      sh4_in   = 8'd150 - ((e != 8'd0) ? e : 8'd1);
   end

   // Stage 5: truncate toward zero, apply the sign and select the format.
   always_comb begin
      logic [54:0] shifted;
      logic [30:0] mag;
      logic [31:0] ival;
      shifted = prod4_ff >> sh4_ff[5:0];
      if (zero4_ff) begin
         mag = 31'd0;
      end else if (sat4_ff) begin
         mag = full_scale(cfg.fmt);
      end else if (sh4_ff >= 8'd64) begin
         mag = 31'd0;
      end else begin
         mag = shifted[30:0];
      end
      ival = bits4_ff[31] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
      case (cfg.fmt)
         FMT_FLOAT: word5_in = bits4_ff;
         FMT_PCM16: word5_in = {16'd0, ival[15:0]};
         FMT_PCM24: word5_in = {8'd0, ival[23:0]};
         default:   word5_in = ival;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en4) begin
            v4_ff <= in_valid;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         bits4_ff <= in_sample.bits;
         last4_ff <= in_sample.last;
         zero4_ff <= zero4_in;
         sat4_ff  <= sat4_in;
         prod4_ff <= prod4_in;
         sh4_ff   <= sh4_in;
      end
      if (en5) begin
         word5_ff  <= word5_in;
         bytes5_ff <= byte_count(cfg.fmt);
         last5_ff  <= last4_ff;
      end
   end

endmodule

/* dv/tb_float_to_pcm_sample_converter.sv */
`timescale 1ns / 1ps

module tb_float_to_pcm_sample_converter;
   import fpcm_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
   } pcm_word_type;

   class pcm_scoreboard;
      cfg_type      cfg;
      pcm_word_type pending_words[$];
      int           errors;

      function new();
         cfg.fmt    = FMT_PCM16;
         cfg.vol_en = 1'b0;
         cfg.gain   = UNITY_GAIN;
         errors     = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [24:0] value);
         case (index)
            CSR_FORMAT: cfg.fmt = value[1:0];
            CSR_VOL_EN: cfg.vol_en = value[0];
            CSR_GAIN: cfg.gain = value;
            default: ;
         endcase
      endfunction

      // Multiplies by gain / 2^24 and rounds to single precision, nearest-even.
      function logic [31:0] scale_by_gain(logic [31:0] bits, logic [24:0] gain);
         logic [7:0]  ex8;
         logic [22:0] frac;
         logic [63:0] mant, prod, rem, half, q;
         int          biased, big, hb, sh, ex;
         ex8  = bits[30:23];
         frac = bits[22:0];
         if (ex8 == 8'hFF) return (gain != 0) ? bits : 32'd0;
         if (ex8 == 8'd0 && frac == 23'd0) return {bits[31], 31'd0};
         mant   = (ex8 != 8'd0) ? {40'd0, 1'b1, frac} : {41'd0, frac};
         biased = (ex8 != 8'd0) ? int'(ex8) : 1;
         prod   = mant * {39'd0, gain};
         if (prod == 64'd0) return {bits[31], 31'd0};
         big = biased - 174;
         hb  = 63;
         while (hb > 0 && !prod[hb]) hb--;
         sh = hb - 23;
         if (-149 - big > sh) sh = -149 - big;
         if (sh > 0) begin
            rem  = prod & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q    = prod >> sh;
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
         end else begin
            q = prod << (-sh);
         end
         ex = big + sh;
         if (q == (64'd1 << 24)) begin
            q = q >> 1;
            ex++;
         end
         if (q >= (64'd1 << 23)) return {bits[31], 8'(ex + 150), q[22:0]};
         return {bits[31], q[30:0]};
      endfunction

      // Clamps to [-1, 1], scales by full-scale k and truncates toward zero.
      function logic [31:0] to_fixed(logic [31:0] bits, logic [30:0] k);
         logic [7:0]  ex8;
         logic [22:0] frac;
         logic [63:0] mant, mag;
         int          sh;
         ex8  = bits[30:23];
         frac = bits[22:0];
         if (ex8 == 8'd0 && frac == 23'd0) begin
            mag = 64'd0;
         end else if (ex8 > 8'd127 || (ex8 == 8'd127 && frac != 23'd0)) begin
            mag = {33'd0, k};
         end else begin
            mant = (ex8 != 8'd0) ? {40'd0, 1'b1, frac} : {41'd0, frac};
            sh   = 150 - ((ex8 != 8'd0) ? int'(ex8) : 1);
            mag  = (sh >= 64) ? 64'd0 : ((mant * {33'd0, k}) >> sh);
         end
         return bits[31] ? (32'd0 - mag[31:0]) : mag[31:0];
      endfunction

      function pcm_word_type convert_sample(sample_type s);
         logic [31:0]  v, fixed;
         pcm_word_type r;
         v = s.bits;
         if (v[30:23] == 8'hFF && v[22:0] != 23'd0) v = 32'd0;
         if (cfg.vol_en && cfg.gain < UNITY_GAIN) v = scale_by_gain(v, cfg.gain);
         r.last = s.last;
         case (cfg.fmt)
            FMT_FLOAT: begin
               r.word   = v;
               r.nbytes = 3'd4;
            end
            FMT_PCM16: begin
               fixed    = to_fixed(v, 31'd32767);
               r.word   = {16'd0, fixed[15:0]};
               r.nbytes = 3'd2;
            end
            FMT_PCM24: begin
               fixed    = to_fixed(v, 31'd8388607);
               r.word   = {8'd0, fixed[23:0]};
               r.nbytes = 3'd3;
            end
            default: begin
               r.word   = to_fixed(v, 31'h7FFFFFFF);
               r.nbytes = 3'd4;
            end
         endcase
         return r;
      endfunction

      function void note_sample(sample_type s);
         pending_words.push_back(convert_sample(s));
      endfunction

      function void check_result(logic [39:0] data, logic last);
         pcm_word_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word data=%h last=%b", $time, data, last);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         if (data[31:0] !== want.word) begin
            $display("%0t: sample_word expected %h actual %h", $time, want.word, data[31:0]);
            errors++;
         end
         if (data[34:32] !== want.nbytes) begin
            $display("%0t: valid_bytes expected %0d actual %0d", $time, want.nbytes,
                     data[34:32]);
            errors++;
         end
         if (data[39:35] !== 5'd0) begin
            $display("%0t: padding bits expected 0 actual %h", $time, data[39:35]);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_words.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [24:0] csr_data;

   pcm_scoreboard sb = new();
   bit            quiet;

   float_to_pcm_sample_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   function int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function logic [31:0] random_sample();
      int          r;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      v = $urandom();
      if (r < 15) begin
         return v;
      end else if (r < 70) begin
         v[30:23] = 8'($urandom_range(103, 126));
      end else if (r < 80) begin
         v[30:23] = 8'($urandom_range(127, 129));
      end else if (r < 88) begin
         v[30:23] = 8'($urandom_range(0, 24));
      end else if (r < 95) begin
         case ($urandom_range(0, 5))
            0: v[30:0] = 31'd0;
            1: v[30:0] = 31'h7F800000;
            2: v[30:23] = 8'hFF;
            3: v[30:0] = 31'h3F800000;
            4: v[30:0] = 31'h3F7FFFFF;
            default: v[30:0] = 31'h3F800001;
         endcase
      end else begin
         v[30:23] = 8'($urandom_range(112, 126));
         v[22:0]  = 23'h7FFFFF - 23'($urandom_range(0, 15));
      end
      return v;
   endfunction

   task automatic send_sample(input logic [31:0] bits, input logic last);
      int         gap;
      sample_type s;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      s.bits = bits;
      s.last = last;
      sb.note_sample(s);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [24:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(index, value);
   endtask

   task automatic apply_settings(input logic [1:0] fmt, input logic en,
                                 input logic [24:0] gain);
      write_csr(CSR_FORMAT, {23'd0, fmt});
      write_csr(CSR_VOL_EN, {24'd0, en});
      write_csr(CSR_GAIN, gain);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   initial begin
      logic [31:0] corners[$];
      logic [24:0] gain;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 32'd0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = 2'd0;
      csr_data   = 25'd0;
      quiet      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pcm16 without gain.
      corners = '{32'h3F800000, 32'hBF800000, 32'h00000000, 32'h80000000, 32'h7F800000,
                  32'hFF800000, 32'h7FC00001, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF,
                  32'h7F7FFFFF, 32'h3F7FFFFF};
      foreach (corners[i]) send_sample(corners[i], i == corners.size() - 1);
      drain();

      // Zero gain in float mode: infinity turns to zero.
      apply_settings(FMT_FLOAT, 1'b1, 25'd0);
      corners = '{32'h7F800000, 32'hFF800000, 32'h3F800000, 32'hBF000000, 32'h7FC00000,
                  32'h80000001};
      foreach (corners[i]) send_sample(corners[i], i[0]);
      drain();

      apply_settings(FMT_PCM32, 1'b1, UNITY_GAIN - 25'd1);
      corners = '{32'h3F800000, 32'hBF800000, 32'h7F7FFFFF, 32'h00000001, 32'hFF800000};
      foreach (corners[i]) send_sample(corners[i], 1'b1);
      drain();

      for (int phase = 0; phase < 14; phase++) begin
         case ($urandom_range(0, 5))
            0: gain = 25'd0;
            1: gain = 25'd1;
            2: gain = UNITY_GAIN - 25'd1;
            3: gain = UNITY_GAIN;
            default: gain = 25'($urandom_range(0, 32'h00FFFFFF));
         endcase
         apply_settings(2'(phase), phase % 3 != 0, gain);
         quiet = (phase % 4 == 2);
         for (int n = 0; n < 60; n++) begin
            if (phase == 5 && n == 30) drain();
            send_sample(random_sample(), $urandom_range(0, 7) == 0);
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
